@@ design/bmhq_pkg.sv @@
// Shared types and constants for the binary max-heap queue unit.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CUR,
    WR_PARENT,
    WR_CHILD
  } wr_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_CHK,
    S_PUSH_CMP,
    S_POP_LOAD,
    S_POP_CHK,
    S_POP_LEFT,
    S_POP_RIGHT,
    S_POP_CMP
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_push;
    logic    load_last;
    rd_sel_e rd_sel;
    logic    take_left;
    logic    pick;
    wr_sel_e wr_sel;
    logic    finish;
    status_e fin_status;
  } hq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic is_root;
    logic left_out;
    logic right_out;
    logic parent_less;
    logic cur_less;
  } hq_stat_t;

endpackage

@@ design/bmhq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bmhq_ctrl.sv @@
// Sequencer for push sift-up and pop sift-down.
// Depends on bmhq_pkg; drives the datapath through hq_cmd_t.
`timescale 1ns / 1ps

module bmhq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               operation_i,
  input  bmhq_pkg::hq_stat_t stat_i,
  output bmhq_pkg::hq_cmd_t  cmd_o,
  output logic               busy
);

  bmhq_pkg::ctl_state_e state_q, state_d;
  logic                 accept;

  assign accept = start && (state_q == bmhq_pkg::S_IDLE);
  assign busy   = (state_q != bmhq_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmhq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          if (operation_i == bmhq_pkg::OP_POP) begin
            if (!stat_i.empty) state_d = bmhq_pkg::S_POP_LOAD;
          end else begin
            if (!stat_i.full) state_d = bmhq_pkg::S_PUSH_CHK;
          end
        end
      end
      bmhq_pkg::S_PUSH_CHK: begin
        state_d = stat_i.is_root ? bmhq_pkg::S_IDLE : bmhq_pkg::S_PUSH_CMP;
      end
      bmhq_pkg::S_PUSH_CMP: begin
        state_d = stat_i.parent_less ? bmhq_pkg::S_PUSH_CHK : bmhq_pkg::S_IDLE;
      end
      bmhq_pkg::S_POP_LOAD: begin
        state_d = bmhq_pkg::S_POP_CHK;
      end
      bmhq_pkg::S_POP_CHK: begin
        state_d = stat_i.left_out ? bmhq_pkg::S_IDLE : bmhq_pkg::S_POP_LEFT;
      end
      bmhq_pkg::S_POP_LEFT: begin
        state_d = stat_i.right_out ? bmhq_pkg::S_POP_CMP : bmhq_pkg::S_POP_RIGHT;
      end
      bmhq_pkg::S_POP_RIGHT: begin
        state_d = bmhq_pkg::S_POP_CMP;
      end
      bmhq_pkg::S_POP_CMP: begin
        state_d = stat_i.cur_less ? bmhq_pkg::S_POP_CHK : bmhq_pkg::S_IDLE;
      end
      default: begin
        state_d = bmhq_pkg::S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o.load_push  = 1'b0;
    cmd_o.load_last  = 1'b0;
    cmd_o.rd_sel     = bmhq_pkg::RD_NONE;
    cmd_o.take_left  = 1'b0;
    cmd_o.pick       = 1'b0;
    cmd_o.wr_sel     = bmhq_pkg::WR_NONE;
    cmd_o.finish     = 1'b0;
    cmd_o.fin_status = bmhq_pkg::ST_OK;
    case (state_q)
      bmhq_pkg::S_IDLE: begin
        if (accept) begin
          if (operation_i == bmhq_pkg::OP_POP) begin
            if (stat_i.empty) begin
              cmd_o.finish     = 1'b1;
              cmd_o.fin_status = bmhq_pkg::ST_EMPTY;
            end else begin
              cmd_o.rd_sel = bmhq_pkg::RD_LAST;
            end
          end else begin
            if (stat_i.full) begin
              cmd_o.finish     = 1'b1;
              cmd_o.fin_status = bmhq_pkg::ST_FULL;
            end else begin
              cmd_o.load_push = 1'b1;
            end
          end
        end
      end
      bmhq_pkg::S_PUSH_CHK: begin
        if (stat_i.is_root) begin
          cmd_o.wr_sel = bmhq_pkg::WR_CUR;
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.rd_sel = bmhq_pkg::RD_PARENT;
        end
      end
      bmhq_pkg::S_PUSH_CMP: begin
        if (stat_i.parent_less) begin
          cmd_o.wr_sel = bmhq_pkg::WR_PARENT;
        end else begin
          cmd_o.wr_sel = bmhq_pkg::WR_CUR;
          cmd_o.finish = 1'b1;
        end
      end
      bmhq_pkg::S_POP_LOAD: begin
        cmd_o.load_last = 1'b1;
      end
      bmhq_pkg::S_POP_CHK: begin
        if (stat_i.left_out) begin
          cmd_o.wr_sel = bmhq_pkg::WR_CUR;
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.rd_sel = bmhq_pkg::RD_LEFT;
        end
      end
      bmhq_pkg::S_POP_LEFT: begin
        cmd_o.take_left = 1'b1;
        if (!stat_i.right_out) cmd_o.rd_sel = bmhq_pkg::RD_RIGHT;
      end
      bmhq_pkg::S_POP_RIGHT: begin
        cmd_o.pick = 1'b1;
      end
      bmhq_pkg::S_POP_CMP: begin
        if (stat_i.cur_less) begin
          cmd_o.wr_sel = bmhq_pkg::WR_CHILD;
        end else begin
          cmd_o.wr_sel = bmhq_pkg::WR_CUR;
          cmd_o.finish = 1'b1;
        end
      end
      default: begin
        cmd_o.finish = 1'b0;
      end
    endcase
  end

endmodule

@@ design/bmhq_dpath.sv @@
// Heap datapath: store, fill count, hole pointer, moving value and result regs.
// Depends on bmhq_pkg and bmhq_ram.
`timescale 1ns / 1ps

module bmhq_dpath #(
  parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF,
  localparam int unsigned PW      = $clog2(CAPACITY + 1),
  localparam int unsigned AW      = $clog2(CAPACITY)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bmhq_pkg::hq_cmd_t                 cmd_i,
  input  logic signed [bmhq_pkg::DATA_W-1:0] value_i,
  output bmhq_pkg::hq_stat_t                stat_o,
  output logic [PW-1:0]                     count_o,
  output logic signed [bmhq_pkg::DATA_W-1:0] top_value_o,
  output logic                              done_o,
  output bmhq_pkg::status_e                 status_o
);

  localparam int unsigned DW = bmhq_pkg::DATA_W;

  logic [PW-1:0]        count_q, count_d;
  logic [PW-1:0]        hole_q, hole_d;
  logic [PW-1:0]        child_pos_q, child_pos_d;
  logic signed [DW-1:0] cur_q, cur_d;
  logic signed [DW-1:0] child_q, child_d;
  logic signed [DW-1:0] top_q, top_d;
  logic                 done_q;
  bmhq_pkg::status_e    status_q, status_d;

  logic [PW:0]          left_pos, right_pos;
  logic [PW-1:0]        parent_pos;
  logic [DW-1:0]        rdata;
  logic signed [DW-1:0] rdata_s;
  logic                 re, we;
  logic [AW-1:0]        raddr, waddr;
  logic [DW-1:0]        wdata;

  assign left_pos   = {hole_q, 1'b0};
  assign right_pos  = {hole_q, 1'b1};
  assign parent_pos = hole_q >> 1;
  assign rdata_s    = signed'(rdata);

  // read address: heap position p lives at address p-1
  always_comb begin
    re    = 1'b1;
    raddr = '0;
    case (cmd_i.rd_sel)
      bmhq_pkg::RD_LAST:   raddr = AW'(count_q - PW'(1));
      bmhq_pkg::RD_PARENT: raddr = AW'(parent_pos - PW'(1));
      bmhq_pkg::RD_LEFT:   raddr = AW'(left_pos - (PW + 1)'(1));
      bmhq_pkg::RD_RIGHT:  raddr = AW'(right_pos - (PW + 1)'(1));
      default:             re    = 1'b0;
    endcase
  end

  assign we    = (cmd_i.wr_sel != bmhq_pkg::WR_NONE);
  assign waddr = AW'(hole_q - PW'(1));

  always_comb begin
    case (cmd_i.wr_sel)
      bmhq_pkg::WR_PARENT: wdata = rdata;
      bmhq_pkg::WR_CHILD:  wdata = child_q;
      default:             wdata = cur_q;
    endcase
  end

  bmhq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    count_d     = count_q;
    hole_d      = hole_q;
    child_pos_d = child_pos_q;
    cur_d       = cur_q;
    child_d     = child_q;
    top_d       = top_q;
    status_d    = status_q;

    if (cmd_i.load_push) begin
      count_d = count_q + PW'(1);
      hole_d  = count_q + PW'(1);
      cur_d   = value_i;
    end
    if (cmd_i.load_last) begin
      count_d = count_q - PW'(1);
      hole_d  = PW'(1);
      cur_d   = rdata_s;
    end
    if (cmd_i.take_left) begin
      child_d     = rdata_s;
      child_pos_d = PW'(left_pos);
    end
    // right child wins unless left is strictly larger
    if (cmd_i.pick && !(child_q > rdata_s)) begin
      child_d     = rdata_s;
      child_pos_d = PW'(right_pos);
    end
    case (cmd_i.wr_sel)
      bmhq_pkg::WR_PARENT: hole_d = parent_pos;
      bmhq_pkg::WR_CHILD:  hole_d = child_pos_q;
      default:             hole_d = hole_d;
    endcase
    // shadow of the root entry
    if (we && (hole_q == PW'(1))) top_d = signed'(wdata);
    if (cmd_i.finish) status_d = cmd_i.fin_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= bmhq_pkg::ST_OK;
    end else begin
      count_q  <= count_d;
      done_q   <= cmd_i.finish;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q      <= hole_d;
    child_pos_q <= child_pos_d;
    cur_q       <= cur_d;
    child_q     <= child_d;
    top_q       <= top_d;
  end

  assign stat_o.full        = (count_q == PW'(CAPACITY));
  assign stat_o.empty       = (count_q == '0);
  assign stat_o.is_root     = (hole_q == PW'(1));
  assign stat_o.left_out    = (left_pos > {1'b0, count_q});
  assign stat_o.right_out   = (right_pos > {1'b0, count_q});
  assign stat_o.parent_less = (rdata_s < cur_q);
  assign stat_o.cur_less    = (cur_q < child_q);

  assign count_o     = count_q;
  assign top_value_o = (count_q == '0) ? '0 : top_q;
  assign done_o      = done_q;
  assign status_o    = status_q;

endmodule

@@ design/binary_max_heap_queue_unit.sv @@
// Binary max-heap priority queue: push a signed value or pop the maximum.
// Accepts an item when start is high and busy is low; exactly one result beat
// follows on done_o, one cycle wide, and cannot be held off. A refused item
// (push when full, pop when empty) gives its beat on the cycle after accept.
// A push moves the hole up one level per PUSH_CHK/PUSH_CMP pass while the
// parent is smaller, then writes the value. A pop loads the last entry in
// POP_LOAD, then per level reads the left child (POP_CHK) and, if present, the
// right child (POP_LEFT), picks the larger (POP_RIGHT) and compares (POP_CMP).
// The pace is set by the heap store, with one write and one read port: one
// read per cycle with registered data, and up to two child reads per level
// on a pop.
// No clearing pass after reset; the store is read only below the fill count.
// Depends on bmhq_pkg, bmhq_ctrl, bmhq_dpath and bmhq_ram.
`timescale 1ns / 1ps

module binary_max_heap_queue_unit #(
  parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic signed [bmhq_pkg::DATA_W-1:0]  value_i,
  output logic                                done_o,
  output logic signed [bmhq_pkg::DATA_W-1:0]  top_value_o,
  output logic                                top_valid_o,
  output logic [bmhq_pkg::COUNT_W-1:0]        entry_count_o,
  output logic [bmhq_pkg::STATUS_W-1:0]       status_o
);

  localparam int unsigned PW = $clog2(CAPACITY + 1);

  bmhq_pkg::hq_cmd_t  cmd;
  bmhq_pkg::hq_stat_t stat;
  bmhq_pkg::status_e  status;
  logic [PW-1:0]      count;
  logic [PW+bmhq_pkg::COUNT_W-1:0] count_ext;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  bmhq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .stat_o      (stat),
    .count_o     (count),
    .top_value_o (top_value_o),
    .done_o      (done_o),
    .status_o    (status)
  );

  assign count_ext     = (PW + bmhq_pkg::COUNT_W)'(count);
  assign entry_count_o = count_ext[bmhq_pkg::COUNT_W-1:0];
  assign top_valid_o   = (count != '0);
  assign status_o      = status;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= PW'(CAPACITY))
    else $error("fill count above capacity");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == bmhq_pkg::OP_POP && count == '0)
      |=> (done_o && status == bmhq_pkg::ST_EMPTY && count == '0))
    else $error("pop from empty heap not refused");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == bmhq_pkg::OP_PUSH && count == PW'(CAPACITY))
      |=> (done_o && status == bmhq_pkg::ST_FULL && $stable(count)))
    else $error("push to full heap not refused");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while still busy");
`endif

endmodule

@@ tb/sv/binary_max_heap_queue_unit_tb.sv @@
// Self-checking testbench for binary_max_heap_queue_unit: a directed table and then
// phased random push/pop traffic, each result beat checked against a heap model.
// Depends on bmhq_pkg and the binary_max_heap_queue_unit RTL.
`timescale 1ns / 1ps

module binary_max_heap_queue_unit_tb;
  import bmhq_pkg::*;

  localparam int unsigned CAPACITY = CAPACITY_DEF;
  localparam int unsigned RANDOM_ITEMS = 1690;
  localparam int unsigned PHASE_LEN = 120;
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] top;
    logic                     valid;
    logic [COUNT_W-1:0]       cnt;
    status_e                  st;
  } heap_res_t;

  // one table row: op, value, repeat count, random value, typed-in result, result
  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] val;
    logic [7:0]               reps;
    logic                     rnd;
    logic                     typed;
    heap_res_t                res;
  } stim_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        operation_i = OP_PUSH;
  logic signed [DATA_W-1:0]    value_i = '0;
  logic                        done_o;
  logic signed [DATA_W-1:0]    top_value_o;
  logic                        top_valid_o;
  logic [COUNT_W-1:0]          entry_count_o;
  logic [STATUS_W-1:0]         status_o;

  logic signed [DATA_W-1:0]    heap_mirror [1:CAPACITY];
  int unsigned                 heap_fill = 0;
  heap_res_t                   due_results [$];
  int unsigned                 mismatch_cnt = 0;

  localparam heap_res_t NO_RES = '{32'sd0, 1'b0, 7'd0, ST_OK};

  stim_row_t dir_tab [21] = '{
    '{OP_POP,  32'sd0,          8'd1,  1'b0, 1'b1, '{32'sd0, 1'b0, 7'd0, ST_EMPTY}},
    '{OP_PUSH, MIN_VAL,         8'd1,  1'b0, 1'b1, '{MIN_VAL, 1'b1, 7'd1, ST_OK}},
    '{OP_PUSH, MAX_VAL,         8'd1,  1'b0, 1'b1, '{MAX_VAL, 1'b1, 7'd2, ST_OK}},
    '{OP_PUSH, -32'sd1,         8'd1,  1'b0, 1'b0, NO_RES},
    '{OP_PUSH, 32'sd0,          8'd1,  1'b0, 1'b0, NO_RES},
    '{OP_PUSH, 32'sd1,          8'd1,  1'b0, 1'b0, NO_RES},
    '{OP_PUSH, MAX_VAL,         8'd1,  1'b0, 1'b0, NO_RES},
    '{OP_PUSH, MIN_VAL,         8'd1,  1'b0, 1'b0, NO_RES},
    '{OP_PUSH, 32'sh5555_5555,  8'd1,  1'b0, 1'b0, NO_RES},
    '{OP_PUSH, 32'shaaaa_aaaa,  8'd1,  1'b0, 1'b0, NO_RES},
    '{OP_POP,  32'sd0,          8'd7,  1'b0, 1'b0, NO_RES},
    // only one of the two minimum entries is left
    '{OP_POP,  32'sd0,          8'd1,  1'b0, 1'b1, '{MIN_VAL, 1'b1, 7'd1, ST_OK}},
    '{OP_POP,  32'sd0,          8'd1,  1'b0, 1'b1, '{32'sd0, 1'b0, 7'd0, ST_OK}},
    '{OP_POP,  -32'sd1,         8'd1,  1'b0, 1'b1, '{32'sd0, 1'b0, 7'd0, ST_EMPTY}},
    // equal keys: nothing may swap
    '{OP_PUSH, 32'sd5,          8'd6,  1'b0, 1'b0, NO_RES},
    '{OP_POP,  32'sd0,          8'd6,  1'b0, 1'b0, NO_RES},
    // fill to capacity under a known maximum, then a refused push
    '{OP_PUSH, MAX_VAL,         8'd1,  1'b0, 1'b1, '{MAX_VAL, 1'b1, 7'd1, ST_OK}},
    '{OP_PUSH, 32'sd0,          8'd63, 1'b1, 1'b0, NO_RES},
    '{OP_PUSH, 32'sd7,          8'd1,  1'b0, 1'b1, '{MAX_VAL, 1'b1, 7'd64, ST_FULL}},
    '{OP_POP,  32'sd0,          8'd64, 1'b1, 1'b0, NO_RES},
    '{OP_POP,  32'sd0,          8'd1,  1'b0, 1'b1, '{32'sd0, 1'b0, 7'd0, ST_EMPTY}}
  };

  binary_max_heap_queue_unit #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .top_value_o  (top_value_o),
    .top_valid_o  (top_valid_o),
    .entry_count_o(entry_count_o),
    .status_o     (status_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("binary_max_heap_queue_unit_tb: done, errors");
    $finish;
  end

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic signed [DATA_W-1:0] t;
    t = heap_mirror[a];
    heap_mirror[a] = heap_mirror[b];
    heap_mirror[b] = t;
  endfunction

  // Applies one push/pop to the mirror heap and returns the result beat it gives.
  function automatic heap_res_t heap_apply(op_e op, logic signed [DATA_W-1:0] val);
    heap_res_t   r;
    int unsigned i;
    int unsigned c;
    r.st = ST_OK;
    if (op == OP_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        r.st = ST_FULL;
      end else begin
        heap_fill++;
        i = heap_fill;
        heap_mirror[i] = val;
        while (i > 1 && heap_mirror[i / 2] < heap_mirror[i]) begin
          swap_entries(i / 2, i);
          i = i / 2;
        end
      end
    end else if (heap_fill == 0) begin
      r.st = ST_EMPTY;
    end else begin
      heap_mirror[1] = heap_mirror[heap_fill];
      heap_fill--;
      i = 1;
      while (2 * i <= heap_fill) begin
        c = 2 * i;
        // right child wins ties
        if (c + 1 <= heap_fill && !(heap_mirror[c] > heap_mirror[c + 1])) c = c + 1;
        if (!(heap_mirror[i] < heap_mirror[c])) break;
        swap_entries(i, c);
        i = c;
      end
    end
    r.valid = (heap_fill != 0);
    r.top   = r.valid ? heap_mirror[1] : '0;
    r.cnt   = COUNT_W'(heap_fill);
    return r;
  endfunction

  task automatic note_err(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  // Holds start low for the gap, then offers one item until it is taken.
  task automatic drive_item(op_e op, logic signed [DATA_W-1:0] val, int unsigned gap,
                            logic typed, heap_res_t typed_res);
    heap_res_t r;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (busy);
    r = heap_apply(op, val);
    due_results.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_all_beats();
    start <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    heap_res_t got;
    heap_res_t want;
    if (rst_ni && done_o) begin
      got = '{top_value_o, top_valid_o, entry_count_o, status_e'(status_o)};
      if (due_results.size() == 0) begin
        note_err($sformatf("unexpected beat: top %0d valid %0b count %0d status %0d",
                           got.top, got.valid, got.cnt, got.st));
      end else begin
        want = due_results.pop_front();
        if (got.top !== want.top || got.valid !== want.valid ||
            got.cnt !== want.cnt || got.st !== want.st)
          note_err($sformatf({"mismatch: exp top %0d valid %0b count %0d status %0d, ",
                              "got top %0d valid %0b count %0d status %0d"},
                             want.top, want.valid, want.cnt, want.st,
                             got.top, got.valid, got.cnt, got.st));
      end
    end
  end

  initial begin
    int unsigned              n;
    int unsigned              push_pct;
    int unsigned              sel;
    logic                     burst;
    op_e                      op;
    logic signed [DATA_W-1:0] val;
    logic signed [DATA_W-1:0] last_val;

    burst    = 1'b0;
    push_pct = 50;
    last_val = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      for (n = 0; n < dir_tab[k].reps; n++) begin
        val = dir_tab[k].rnd ? $signed($urandom) : dir_tab[k].val;
        drive_item(dir_tab[k].op, val, $urandom_range(0, 14), dir_tab[k].typed,
                   dir_tab[k].res);
      end
    end
    wait_all_beats();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0) wait_all_beats();
      end
      op  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        val = $signed($urandom);
      end else if (sel <= 7) begin
        val = $signed($urandom_range(0, 8)) - 32'sd4;
      end else if (sel == 8) begin
        case ($urandom_range(0, 3))
          0: val = MIN_VAL;
          1: val = MAX_VAL;
          2: val = 32'sd0;
          default: val = -32'sd1;
        endcase
      end else begin
        val = last_val;
      end
      if (op == OP_PUSH) last_val = val;
      drive_item(op, val, burst ? 0 : $urandom_range(0, 14), 1'b0, NO_RES);
    end

    wait_all_beats();
    // catch any stray beat after the last expected one
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("binary_max_heap_queue_unit_tb: done, clean");
    end else begin
      $display("binary_max_heap_queue_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
